// ===== hw/rtl/sfl_pkg.sv =====
package sfl_pkg;

  localparam int FRAC_W  = 16;   // fraction bits of every vector value
  localparam int SUM_W   = 32;   // accumulated vector component width
  localparam int DIR_W   = 24;   // direction component width
  localparam int OUT_W   = 24;   // force component width
  localparam int MF_W    = 23;   // max_force register width
  localparam int CNT_W   = 8;    // neighbour count width
  localparam int DW      = 32;   // divider word: remainder, divisor, quotient
  localparam int RAD_W   = 64;   // square root radicand width
  localparam int ROOT_W  = RAD_W / 2;
  localparam int STEPS   = 32;   // stages in the divider and the square root
  localparam int UQ_W    = FRAC_W + 1;       // unit component magnitude
  localparam int D_W     = OUT_W + 2;        // signed difference width
  localparam int DMAG_W  = OUT_W;            // difference magnitude width
  localparam int DSQ_W   = 2 * DMAG_W;
  localparam int DRAD_W  = DSQ_W + 2;
  localparam int PROD_W  = DMAG_W + MF_W;

  localparam logic [MF_W-1:0] MF_RESET = MF_W'(1 << FRAC_W);
  localparam logic [OUT_W-1:0] OUT_POS_SAT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

  // sideband after the input register (through the count dividers)
  typedef struct packed {
    logic                           invalid;
    logic [2:0]                     neg;
    logic [2:0][DIR_W-1:0]          dir;
  } side_a_t;

  // sideband through the first square root
  typedef struct packed {
    side_a_t                        a;
    logic [2:0][SUM_W-1:0]          m;
  } side_b_t;

  // sideband through the unit dividers
  typedef struct packed {
    side_a_t                        a;
    logic                           len_zero;
  } side_c_t;

  // difference vector as magnitude and sign
  typedef struct packed {
    logic                           invalid;
    logic [2:0]                     neg;
    logic [2:0][DMAG_W-1:0]         mag;
  } side_d_t;

  // sideband through the limit dividers
  typedef struct packed {
    side_d_t                        d;
    logic                           limit;
  } side_e_t;

endpackage

// ===== hw/rtl/steering_force_limiter_core.sv =====
// Steering force limiter: boids style steering with a magnitude limit.
// Input channel (in_*): accumulated neighbour vector and the agent's direction,
// both signed fixed point with 16 fraction bits, and the unsigned neighbour
// count. Result channel (out_*): one force vector per transaction plus
// count_invalid, set (with a zero force) when the neighbour count was zero.
// Config: cfg_we writes cfg_wdata into max_force; write only while idle.
// Datapath: input register, 32-stage divide by count, square and sum, 32-stage
// square root, 32-stage divide giving the unit vector, difference, square and
// sum, second 32-stage square root, max_force product, 32-stage limit divide,
// output register, 168 registers deep. The divider and root pipelines retire
// one bit per stage. Throughput is one transaction per cycle, back to back,
// while out_stall does not freeze the pipe.
// Stall: all stages advance together. When the output register holds a
// transaction and out_stall is high the whole pipe freezes and in_stall is
// raised; nothing is dropped or repeated and out_* hold steady.
// Reset (rst_n low, synchronous): all valid bits clear, max_force returns to
// 1.0 (65536). No clearing pass is needed.
module steering_force_limiter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [sfl_pkg::SUM_W-1:0] in_sum_x,
  input  logic signed [sfl_pkg::SUM_W-1:0] in_sum_y,
  input  logic signed [sfl_pkg::SUM_W-1:0] in_sum_z,
  input  logic [sfl_pkg::CNT_W-1:0]        in_neighbour_count,
  input  logic signed [sfl_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [sfl_pkg::DIR_W-1:0] in_dir_y,
  input  logic signed [sfl_pkg::DIR_W-1:0] in_dir_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sfl_pkg::OUT_W-1:0] out_force_x,
  output logic signed [sfl_pkg::OUT_W-1:0] out_force_y,
  output logic signed [sfl_pkg::OUT_W-1:0] out_force_z,
  output logic                             out_count_invalid,
  input  logic                             cfg_we,
  input  logic [sfl_pkg::MF_W-1:0]         cfg_wdata
);
  import sfl_pkg::*;

  logic en;

  // max_force register
  logic [MF_W-1:0] mf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mf_r <= MF_RESET;
    end else if (cfg_we) begin
      mf_r <= cfg_wdata;
    end
  end

  // ---------------- input register ----------------
  logic [2:0][SUM_W-1:0] sum_w;
  logic                  v0_r;
  side_a_t               a0_r;
  logic [2:0][SUM_W-1:0] mag0_r;
  logic [CNT_W-1:0]      cnt0_r;

  assign sum_w[0] = in_sum_x;
  assign sum_w[1] = in_sum_y;
  assign sum_w[2] = in_sum_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a0_r.neg[i] <= sum_w[i][SUM_W-1];
        // magnitude of the most negative value still fits unsigned
        mag0_r[i]   <= sum_w[i][SUM_W-1] ? SUM_W'(-sum_w[i]) : sum_w[i];
      end
      a0_r.invalid <= (in_neighbour_count == '0);
      a0_r.dir[0]  <= in_dir_x;
      a0_r.dir[1]  <= in_dir_y;
      a0_r.dir[2]  <= in_dir_z;
      cnt0_r       <= in_neighbour_count;
    end
  end

  // ---------------- average = |sum| / count ----------------
  logic [2:0][DW-1:0] avg_q;
  logic [STEPS-1:0]   va_r;
  side_a_t            pa_r [STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_cdiv
    sfl_div u_cdiv (
      .clk  (clk),
      .en   (en),
      .rem0 ('0),
      .low  (mag0_r[i]),
      .div  (DW'(cnt0_r)),
      .quo  (avg_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
    end else if (en) begin
      va_r <= {va_r[STEPS-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= a0_r;
      for (int k = 1; k < STEPS; k++) begin
        pa_r[k] <= pa_r[k-1];
      end
    end
  end

  // ---------------- squares, then their sum ----------------
  logic                     v1_r, v2_r;
  side_a_t                  a1_r, a2_r;
  logic [2:0][SUM_W-1:0]    m1_r, m2_r;
  logic [2:0][RAD_W-1:0]    sq1_r;
  logic [RAD_W-1:0]         rad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= va_r[STEPS-1];
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= pa_r[STEPS-1];
      for (int i = 0; i < 3; i++) begin
        m1_r[i]  <= avg_q[i];
        sq1_r[i] <= avg_q[i] * avg_q[i];
      end
      a2_r   <= a1_r;
      m2_r   <= m1_r;
      // averages never exceed 2^31, so the sum fits 64 bits
      rad2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  // ---------------- length of the average ----------------
  logic [ROOT_W-1:0] len1;
  logic [STEPS-1:0]  vb_r;
  side_b_t           pb_r [STEPS];
  side_b_t           b2;

  assign b2.a = a2_r;
  assign b2.m = m2_r;

  sfl_isqrt u_len1 (
    .clk  (clk),
    .en   (en),
    .rad  (rad2_r),
    .root (len1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (en) begin
      vb_r <= {vb_r[STEPS-2:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r[0] <= b2;
      for (int k = 1; k < STEPS; k++) begin
        pb_r[k] <= pb_r[k-1];
      end
    end
  end

  // ---------------- unit vector = (m << 16) / len ----------------
  logic [2:0][DW-1:0] unit_q;
  logic [STEPS-1:0]   vc_r;
  side_c_t            pc_r [STEPS];
  side_c_t            c_in;

  assign c_in.a        = pb_r[STEPS-1].a;
  assign c_in.len_zero = (len1 == '0);

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    sfl_div u_udiv (
      .clk  (clk),
      .en   (en),
      .rem0 (DW'(pb_r[STEPS-1].m[i][SUM_W-1:FRAC_W])),
      .low  ({pb_r[STEPS-1].m[i][FRAC_W-1:0], {(DW-FRAC_W){1'b0}}}),
      .div  (DW'(len1)),
      .quo  (unit_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (en) begin
      vc_r <= {vc_r[STEPS-2:0], vb_r[STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0] <= c_in;
      for (int k = 1; k < STEPS; k++) begin
        pc_r[k] <= pc_r[k-1];
      end
    end
  end

  // ---------------- difference = unit - dir ----------------
  side_c_t                c_out;
  logic signed [D_W-1:0]  u_s [3];
  logic signed [D_W-1:0]  d_s [3];
  side_d_t                d_nxt;

  assign c_out = pc_r[STEPS-1];

  always_comb begin
    d_nxt.invalid = c_out.a.invalid;
    for (int i = 0; i < 3; i++) begin
      if (c_out.len_zero) begin
        u_s[i] = '0;
      end else if (c_out.a.neg[i]) begin
        u_s[i] = -$signed(D_W'(unit_q[i][UQ_W-1:0]));
      end else begin
        u_s[i] = $signed(D_W'(unit_q[i][UQ_W-1:0]));
      end
      d_s[i]          = u_s[i] - D_W'($signed(c_out.a.dir[i]));
      d_nxt.neg[i]    = d_s[i][D_W-1];
      d_nxt.mag[i]    = d_s[i][D_W-1] ? DMAG_W'(-d_s[i]) : DMAG_W'(d_s[i]);
    end
  end

  logic                   v3_r, v4_r, v5_r;
  side_d_t                d3_r, d4_r, d5_r;
  logic [2:0][DSQ_W-1:0]  sq4_r;
  logic [DRAD_W-1:0]      rad5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= vc_r[STEPS-1];
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r <= d_nxt;
      d4_r <= d3_r;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= d3_r.mag[i] * d3_r.mag[i];
      end
      d5_r   <= d4_r;
      rad5_r <= DRAD_W'(sq4_r[0]) + DRAD_W'(sq4_r[1]) + DRAD_W'(sq4_r[2]);
    end
  end

  // ---------------- length of the difference ----------------
  logic [ROOT_W-1:0] len2;
  logic [STEPS-1:0]  vd_r;
  side_d_t           pd_r [STEPS];

  sfl_isqrt u_len2 (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'(rad5_r)),
    .root (len2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[STEPS-2:0], v5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= d5_r;
      for (int k = 1; k < STEPS; k++) begin
        pd_r[k] <= pd_r[k-1];
      end
    end
  end

  // ---------------- limit: |d| * max_force / len ----------------
  logic                    v6_r;
  side_e_t                 e6_r;
  logic [2:0][PROD_W-1:0]  prod6_r;
  logic [ROOT_W-1:0]       len6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= vd_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e6_r.d     <= pd_r[STEPS-1];
      e6_r.limit <= len2 > ROOT_W'(mf_r);
      len6_r     <= len2;
      for (int i = 0; i < 3; i++) begin
        prod6_r[i] <= pd_r[STEPS-1].mag[i] * mf_r;
      end
    end
  end

  logic [2:0][DW-1:0] lim_q;
  logic [STEPS-1:0]   ve_r;
  side_e_t            pe_r [STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_ldiv
    sfl_div u_ldiv (
      .clk  (clk),
      .en   (en),
      .rem0 (DW'(prod6_r[i][PROD_W-1:DW])),
      .low  (prod6_r[i][DW-1:0]),
      .div  (DW'(len6_r)),
      .quo  (lim_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= '0;
    end else if (en) begin
      ve_r <= {ve_r[STEPS-2:0], v6_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe_r[0] <= e6_r;
      for (int k = 1; k < STEPS; k++) begin
        pe_r[k] <= pe_r[k-1];
      end
    end
  end

  // ---------------- sign, saturate, output register ----------------
  side_e_t               e_out;
  logic [DMAG_W-1:0]     fmag [3];
  logic [2:0][OUT_W-1:0] f_nxt;
  logic                  out_valid_r;
  logic [2:0][OUT_W-1:0] force_r;
  logic                  invalid_r;

  assign e_out = pe_r[STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmag[i] = e_out.limit ? lim_q[i][DMAG_W-1:0] : e_out.d.mag[i];
      if (e_out.d.invalid) begin
        f_nxt[i] = '0;
      end else if (e_out.d.neg[i]) begin
        f_nxt[i] = fmag[i][DMAG_W-1] ? OUT_NEG_SAT : OUT_W'(-fmag[i]);
      end else begin
        f_nxt[i] = fmag[i][DMAG_W-1] ? OUT_POS_SAT : fmag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ve_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r   <= f_nxt;
      invalid_r <= e_out.d.invalid;
    end
  end

  // the whole pipe moves unless a finished transaction is held at the output
  assign en                = !(out_valid_r && out_stall);
  assign in_stall          = !en;
  assign out_valid         = out_valid_r;
  assign out_force_x       = force_r[0];
  assign out_force_y       = force_r[1];
  assign out_force_z       = force_r[2];
  assign out_count_invalid = invalid_r;

endmodule

// ===== hw/rtl/sfl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Dividend is {rem0, low}; rem0 must be below div for a valid quotient.
module sfl_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [sfl_pkg::DW-1:0] rem0,
  input  logic [sfl_pkg::DW-1:0] low,
  input  logic [sfl_pkg::DW-1:0] div,
  output logic [sfl_pkg::DW-1:0] quo
);
  import sfl_pkg::*;

  logic [DW-1:0] rem_r [STEPS];
  logic [DW-1:0] low_r [STEPS];
  logic [DW-1:0] div_r [STEPS];
  logic [DW-1:0] rem_nxt [STEPS];
  logic [DW-1:0] low_nxt [STEPS];
  logic [DW-1:0] rem_in [STEPS];
  logic [DW-1:0] low_in [STEPS];
  logic [DW-1:0] div_in [STEPS];
  logic [DW:0]   trial [STEPS];
  logic          qbit [STEPS];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        rem_in[k] = rem0;
        low_in[k] = low;
        div_in[k] = div;
      end else begin
        rem_in[k] = rem_r[k-1];
        low_in[k] = low_r[k-1];
        div_in[k] = div_r[k-1];
      end
      trial[k] = {rem_in[k], low_in[k][DW-1]};
      qbit[k]  = trial[k] >= {1'b0, div_in[k]};
      if (qbit[k]) begin
        rem_nxt[k] = DW'(trial[k] - {1'b0, div_in[k]});
      end else begin
        rem_nxt[k] = trial[k][DW-1:0];
      end
      low_nxt[k] = {low_in[k][DW-2:0], qbit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        div_r[k] <= div_in[k];
      end
    end
  end

  assign quo = low_r[STEPS-1];

endmodule

// ===== hw/rtl/sfl_isqrt.sv =====
// Pipelined integer square root, floor(sqrt(rad)), one result bit per stage.
module sfl_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sfl_pkg::RAD_W-1:0]  rad,
  output logic [sfl_pkg::ROOT_W-1:0] root
);
  import sfl_pkg::*;

  logic [RAD_W-1:0] v_r [STEPS];
  logic [RAD_W-1:0] r_r [STEPS];
  logic [RAD_W-1:0] v_nxt [STEPS];
  logic [RAD_W-1:0] r_nxt [STEPS];
  logic [RAD_W-1:0] v_in [STEPS];
  logic [RAD_W-1:0] r_in [STEPS];
  logic [RAD_W-1:0] bitc [STEPS];
  logic [RAD_W-1:0] tst [STEPS];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      bitc[k] = RAD_W'(1) << (2 * (STEPS - 1 - k));
      if (k == 0) begin
        v_in[k] = rad;
        r_in[k] = '0;
      end else begin
        v_in[k] = v_r[k-1];
        r_in[k] = r_r[k-1];
      end
      tst[k] = r_in[k] + bitc[k];
      if (v_in[k] >= tst[k]) begin
        v_nxt[k] = v_in[k] - tst[k];
        r_nxt[k] = (r_in[k] >> 1) + bitc[k];
      end else begin
        v_nxt[k] = v_in[k];
        r_nxt[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= v_nxt[k];
        r_r[k] <= r_nxt[k];
      end
    end
  end

  assign root = r_r[STEPS-1][ROOT_W-1:0];

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sfl_pkg::*;

  // Pipe depth in registers, from the block's header.
  localparam int PIPE_LAT = 168;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SUM_W-1:0] in_sum_x = '0, in_sum_y = '0, in_sum_z = '0;
  logic [CNT_W-1:0] in_neighbour_count = '0;
  logic signed [DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_force_x, out_force_y, out_force_z;
  logic out_count_invalid;
  logic cfg_we = 1'b0;
  logic [MF_W-1:0] cfg_wdata = '0;

  typedef struct {
    logic signed [OUT_W-1:0] fx, fy, fz;
    logic inv;
  } force_t;

  force_t force_q[$];
  logic [MF_W-1:0] max_force_shadow;
  int n_errors = 0;
  bit pattern_stall_en = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  steering_force_limiter_core u_top (.*);

  // integer sqrt, bit by bit, floor
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Steering force: average, normalize, subtract direction, clamp to max_force.
  function automatic force_t steer_force(input logic signed [SUM_W-1:0] sx, sy, sz,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic signed [DIR_W-1:0] ddx, ddy, ddz);
    force_t f;
    logic signed [63:0] s[3], dir[3], d[3], fv;
    logic [63:0] m[3], len, sq, a, q;
    logic signed [63:0] u;
    f.inv = 1'b0;
    if (cnt == 0) begin
      f.fx = '0; f.fy = '0; f.fz = '0; f.inv = 1'b1;
      return f;
    end
    s[0] = sx; s[1] = sy; s[2] = sz;
    dir[0] = ddx; dir[1] = ddy; dir[2] = ddz;
    for (int i = 0; i < 3; i++) m[i] = (s[i] < 0 ? -s[i] : s[i]) / cnt;
    // wide average: shift all together until each fits 2^31
    while (m[0] > 64'h8000_0000 || m[1] > 64'h8000_0000 || m[2] > 64'h8000_0000)
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      u = 0;
      if (len != 0) begin
        q = (m[i] << FRAC_W) / len;
        u = (s[i] < 0) ? -$signed(q) : $signed(q);
      end
      d[i] = u - dir[i];
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a = d[i] < 0 ? -d[i] : d[i];
      sq += a * a;
    end
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      if (len > max_force_shadow) begin
        a = d[i] < 0 ? -d[i] : d[i];
        q = a * max_force_shadow / len;
        fv = d[i] < 0 ? -$signed(q) : $signed(q);
      end else begin
        fv = d[i];
      end
      if (fv > 64'sd8388607) fv = 64'sd8388607;
      if (fv < -64'sd8388608) fv = -64'sd8388608;
      case (i)
        0: f.fx = fv[OUT_W-1:0];
        1: f.fy = fv[OUT_W-1:0];
        default: f.fz = fv[OUT_W-1:0];
      endcase
    end
    return f;
  endfunction

  // Send one transaction and queue its predicted force.
  task automatic send_item(input logic signed [SUM_W-1:0] sx, sy, sz,
                           input logic [CNT_W-1:0] cnt,
                           input logic signed [DIR_W-1:0] ddx, ddy, ddz);
    in_valid <= 1'b1;
    in_sum_x <= sx; in_sum_y <= sy; in_sum_z <= sz;
    in_neighbour_count <= cnt;
    in_dir_x <= ddx; in_dir_y <= ddy; in_dir_z <= ddz;
    do @(posedge clk); while (in_stall);
    force_q.push_back(steer_force(sx, sy, sz, cnt, ddx, ddy, ddz));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // Drain: wait for every result, then let the pipe settle before a write.
  task automatic drain();
    go_idle();
    while (force_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_max_force(input logic [MF_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_force_shadow = v;
  endtask

  // Random gap between bursts.
  task automatic sender_gap();
    go_idle();
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sum();
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh8_0000;
      2: return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_dir();
    case ($urandom_range(0, 2))
      0: return $signed(24'($urandom()));
      1: return $signed(24'($urandom_range(0, 24'h2_0000))) - 24'sh1_0000;
      default: return $signed(24'($urandom())) >>> $urandom_range(0, 23);
    endcase
  endfunction

  function automatic logic [7:0] rand_cnt();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_random(input int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 1)) sender_gap();
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_item(rand_sum(), rand_sum(), rand_sum(), rand_cnt(),
                rand_dir(), rand_dir(), rand_dir());
    end
  endtask

  // Extremes of every field, zero count, zero average, wide average.
  task automatic test_directed();
    send_item(0, 0, 0, 0, 0, 0, 0);
    send_item(32'sh7fff_ffff, 5, -7, 0, 24'sh7f_ffff, 1, 2);
    send_item(0, 0, 0, 3, 24'sh1_0000, 0, 0);
    send_item(0, 0, 0, 1, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000);
    send_item(0, 0, 0, 255, 24'sh7f_ffff, 24'sh7f_ffff, 24'sh7f_ffff);
    send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 0, 0);
    send_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0, 0, 0);
    send_item(32'sh8000_0000, 0, 0, 1, 24'sh1_0000, 0, 0);
    send_item(32'sh8000_0000, 32'sh7fff_ffff, -1, 255, 24'sh7f_ffff, 24'sh80_0000, 0);
    send_item(32'sh1_0000, 0, 0, 1, 24'sh1_0000, 0, 0);
    send_item(32'sh1_0000, 0, 0, 1, -24'sh1_0000, 0, 0);
    send_item(0, 32'sh1_0000, 0, 2, 0, 0, 24'sh1_0000);
    send_item(-1, -1, -1, 255, -1, -1, -1);
    send_item(1, 1, 1, 1, 1, 1, 1);
    send_item(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 8'haa, 24'h55_5555,
              24'haa_aaaa, 24'h33_3333);
    send_item(32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0, 8'h55, 24'haa_aaaa,
              24'h55_5555, 24'hcc_cccc);
    drain();
  endtask

  // Run under several limits, extremes included.
  task automatic test_limits();
    logic [MF_W-1:0] lim[6];
    lim = '{23'd0, 23'd1, 23'h7f_ffff, 23'd32768, 23'd131072, 23'd65536};
    foreach (lim[k]) begin
      write_max_force(lim[k]);
      test_directed();
      send_random(200);
      drain();
    end
  endtask

  task automatic test_random_limit();
    write_max_force(23'($urandom()));
    send_random(200);
    drain();
  endtask

  task automatic test_full_rate();
    // No gaps and no receiver stalls: back-to-back throughput.
    pattern_stall_en = 1'b0;
    write_max_force(23'd65536);
    for (int i = 0; i < 100; i++)
      send_item(rand_sum(), rand_sum(), rand_sum(), rand_cnt(),
                rand_dir(), rand_dir(), rand_dir());
    drain();
    pattern_stall_en = 1'b1;
  endtask

  // Receiver stall: a random mix of quiet and busy stretches with random duty.
  initial begin
    int seg;
    forever begin
      seg = $urandom_range(5, 60);
      if (!pattern_stall_en || $urandom_range(0, 3) == 0) begin
        repeat (seg) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end else begin
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      end
    end
  end

  // Result checker: compare each accepted transaction with the oldest prediction.
  always @(posedge clk) begin
    force_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (force_q.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        e = force_q.pop_front();
        if (out_force_x !== e.fx) begin
          $error("force_x exp %0d got %0d", e.fx, out_force_x); n_errors++;
        end
        if (out_force_y !== e.fy) begin
          $error("force_y exp %0d got %0d", e.fy, out_force_y); n_errors++;
        end
        if (out_force_z !== e.fz) begin
          $error("force_z exp %0d got %0d", e.fz, out_force_z); n_errors++;
        end
        if (out_count_invalid !== e.inv) begin
          $error("count_invalid exp %0d got %0d", e.inv, out_count_invalid);
          n_errors++;
        end
      end
    end
  end

  initial begin
    max_force_shadow = MF_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();      // reset value of max_force
    test_limits();
    test_random_limit();
    test_full_rate();
    if (force_q.size() != 0) n_errors++;
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
